// File: rtl/dsp_data_address_generator_defines.svh
// Assertion macros shared by the data-address generator RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef DSP_DATA_ADDRESS_GENERATOR_DEFINES_SVH
`define DSP_DATA_ADDRESS_GENERATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define DAG_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dag assertion failed");
`define DAG_ASSERT(label, prop) `DAG_ASSERT_CLK(label, clock, reset, prop)
`else
`define DAG_ASSERT_CLK(label, clk, rst, prop)
`define DAG_ASSERT(label, prop)
`endif
`endif

// File: rtl/dag_pkg.sv
// Types and constants for the data-address generator.
// Depends on nothing; used by every module of the block.
package dag_pkg;

   // configuration register indexes
   localparam logic CSR_CIRC_SIZE = 1'b0;
   localparam logic CSR_COMPAT    = 1'b1;

   // operand byte layout
   localparam int        OP_INDIRECT_BIT = 7;
   localparam logic [7:0] OP_OFFSET_MASK = 8'h7f;
   localparam logic [7:0] OP_MOD_MASK    = 8'(8 + 16 + 32 + 64);
   localparam logic [8:0] DP_MASK        = 9'h1ff;

   // direct base selects
   localparam logic [1:0] BASE_PAGE  = 2'd0;
   localparam logic [1:0] BASE_STACK = 2'd1;

   // item classes passed from front to back
   localparam logic [1:0] KIND_WRITE    = 2'd0;
   localparam logic [1:0] KIND_DIRECT   = 2'd1;
   localparam logic [1:0] KIND_INDIRECT = 2'd2;

   // indirect modifiers
   localparam logic [3:0] MOD_PLAIN    = 4'd0;
   localparam logic [3:0] MOD_POSTDEC  = 4'd1;
   localparam logic [3:0] MOD_POSTINC  = 4'd2;
   localparam logic [3:0] MOD_PREINC   = 4'd3;
   localparam logic [3:0] MOD_REVSUB   = 4'd4;
   localparam logic [3:0] MOD_SUBAR0   = 4'd5;
   localparam logic [3:0] MOD_ADDAR0   = 4'd6;
   localparam logic [3:0] MOD_REVADD   = 4'd7;
   localparam logic [3:0] MOD_CDEC     = 4'd8;
   localparam logic [3:0] MOD_CSUBAR0  = 4'd9;
   localparam logic [3:0] MOD_CINC     = 4'd10;
   localparam logic [3:0] MOD_CADDAR0  = 4'd11;
   localparam logic [3:0] MOD_LKOFS    = 4'd12;
   localparam logic [3:0] MOD_LKPRE    = 4'd13;
   localparam logic [3:0] MOD_LKCIRC   = 4'd14;
   localparam logic [3:0] MOD_LKABS    = 4'd15;

   localparam int QDEPTH = 2;

   typedef struct packed {
      logic        mode;
      logic [7:0]  operand_byte;
      logic [15:0] long_offset;
      logic [1:0]  base_select;
      logic [8:0]  data_page;
      logic [15:0] stack_pointer;
      logic [2:0]  current_pointer;
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
   } req_type;

   typedef struct packed {
      logic [15:0] address;
      logic [2:0]  pointer_used;
      logic [15:0] pointer_after;
      logic        two_word;
   } rsp_type;

   // classified item: data is the direct address, long offset or load value
   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  modifier;
      logic [2:0]  ptr;
      logic [15:0] data;
   } item_type;

   typedef struct packed {
      logic [15:0] circ_size;
      logic [15:0] circ_mask;
      logic        compat;
   } cfg_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [1:0] count;
   } qstat_type;

endpackage

// File: rtl/dag_front.sv
// Front stage: accepts items, resolves pointer number, builds direct addresses.
// Depends on dag_pkg.
module dag_front #(
   parameter int ADDR_BITS    = 16,
   parameter int NUM_POINTERS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dag_pkg::req_type   req_payload,
   input  dag_pkg::cfg_type   cfg,
   output logic               q_push,
   input  logic               q_full,
   output dag_pkg::item_type  q_item
);

   localparam logic [15:0] AMASK16 =
      (ADDR_BITS >= 16) ? 16'hffff : 16'((32'd1 << ADDR_BITS) - 32'd1);

   logic              valid_ff, valid_in;
   dag_pkg::item_type item_ff, item_in;
   logic              accept;
   logic [16:0]       dsum;
   logic [16:0]       base;
   logic [4:0]        pv;
   logic [2:0]        field;

   assign req_ready = !valid_ff || !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = valid_ff && !q_full;
   assign q_item    = item_ff;
   assign valid_in  = accept || (valid_ff && !q_push);

   always_comb begin
      base    = '0;
      item_in = '0;
      field   = req_payload.operand_byte[2:0];
      if (cfg.compat && field == 3'd0) begin
         field = req_payload.current_pointer;
      end
      if (req_payload.base_select == dag_pkg::BASE_STACK) begin
         base = 17'(req_payload.stack_pointer);
      end else if (req_payload.base_select == dag_pkg::BASE_PAGE) begin
         base = 17'({req_payload.data_page & dag_pkg::DP_MASK, 7'd0});
      end
      dsum = 17'(req_payload.operand_byte & dag_pkg::OP_OFFSET_MASK) + base;
      // pointer number modulo the register count (at most three folds)
      pv = 5'(field);
      for (int k = 0; k < 3; k++) begin
         if (pv >= 5'(NUM_POINTERS)) begin
            pv = pv - 5'(NUM_POINTERS);
         end
      end
      item_in.modifier = 4'((req_payload.operand_byte & dag_pkg::OP_MOD_MASK) >> 3);
      if (req_payload.mode) begin
         pv = 5'(req_payload.reg_index);
         for (int k = 0; k < 3; k++) begin
            if (pv >= 5'(NUM_POINTERS)) begin
               pv = pv - 5'(NUM_POINTERS);
            end
         end
         item_in.kind = dag_pkg::KIND_WRITE;
         item_in.data = req_payload.reg_value;
      end else if (!req_payload.operand_byte[dag_pkg::OP_INDIRECT_BIT]) begin
         item_in.kind = dag_pkg::KIND_DIRECT;
         item_in.data = dsum[15:0] & AMASK16;
      end else begin
         item_in.kind = dag_pkg::KIND_INDIRECT;
         item_in.data = req_payload.long_offset;
      end
      item_in.ptr = pv[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: rtl/dag_queue.sv
// Two-entry item queue between front and back stages.
// Depends on dag_pkg.
module dag_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dag_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output dag_pkg::item_type  head_item,
   output dag_pkg::qstat_type stat
);

   dag_pkg::item_type slot_ff [dag_pkg::QDEPTH];
   logic              wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]        count_ff, count_in;

   assign full       = (count_ff == 2'(dag_pkg::QDEPTH));
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot_ff[rd_ff];
   assign wr_in      = push ? !wr_ff : wr_ff;
   assign rd_in      = pop ? !rd_ff : rd_ff;
   assign count_in   = count_ff + 2'(push) - 2'(pop);
   assign stat       = '{push: push, pop: pop, count: count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/dag_back.sv
// Back stage: pointer registers, modifier arithmetic and the result register.
// Depends on dag_pkg.
module dag_back #(
   parameter int ADDR_BITS    = 16,
   parameter int NUM_POINTERS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  dag_pkg::item_type  head_item,
   output logic               pop,
   input  dag_pkg::cfg_type   cfg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dag_pkg::rsp_type   rsp_payload
);

   localparam int PW = (NUM_POINTERS > 1) ? $clog2(NUM_POINTERS) : 1;
   localparam int SW = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 2;

   logic [ADDR_BITS-1:0] ptr_ff [NUM_POINTERS];
   logic                 valid_ff;
   dag_pkg::rsp_type     rsp_ff, rsp_in;

   logic [PW-1:0]        idx;
   logic [ADDR_BITS-1:0] p, ar0, newp, addr, lin, circ, mask_ab, cbase;
   logic signed [SW-1:0] step, ar0_s, lk_s, s, size_s;
   logic                 use_circ, wr_en;

   function automatic logic [ADDR_BITS-1:0] rev(input logic [ADDR_BITS-1:0] v);
      logic [ADDR_BITS-1:0] r;
      for (int i = 0; i < ADDR_BITS; i++) begin
         r[ADDR_BITS-1-i] = v[i];
      end
      return r;
   endfunction

   assign pop = head_valid && (!valid_ff || rsp_ready);
   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      idx     = PW'(head_item.ptr);
      p       = ptr_ff[idx];
      ar0     = ptr_ff[0];
      ar0_s   = SW'($signed(ar0));
      lk_s    = SW'($signed(head_item.data));
      mask_ab = ADDR_BITS'(cfg.circ_mask);
      size_s  = $signed(SW'(cfg.circ_size));
      step    = '0;
      use_circ = 1'b0;
      unique case (head_item.modifier)
         dag_pkg::MOD_POSTDEC, dag_pkg::MOD_CDEC:         step = -SW'(1);
         dag_pkg::MOD_POSTINC, dag_pkg::MOD_PREINC,
         dag_pkg::MOD_CINC:                               step = SW'(1);
         dag_pkg::MOD_SUBAR0, dag_pkg::MOD_CSUBAR0:       step = -ar0_s;
         dag_pkg::MOD_ADDAR0, dag_pkg::MOD_CADDAR0:       step = ar0_s;
         dag_pkg::MOD_LKOFS, dag_pkg::MOD_LKPRE,
         dag_pkg::MOD_LKCIRC:                             step = lk_s;
         default:                                         step = '0;
      endcase
      unique case (head_item.modifier)
         dag_pkg::MOD_CDEC, dag_pkg::MOD_CSUBAR0, dag_pkg::MOD_CINC,
         dag_pkg::MOD_CADDAR0, dag_pkg::MOD_LKCIRC: use_circ = (cfg.circ_size != 16'd0);
         default:                                   use_circ = 1'b0;
      endcase

      lin   = ADDR_BITS'(SW'(p) + step);
      // circular: one correction by the buffer size, then rebase
      cbase = p & ~mask_ab;
      s     = $signed(SW'(p & mask_ab)) + step;
      if (s < 0) begin
         s = s + size_s;
      end else if (s >= size_s) begin
         s = s - size_s;
      end
      circ  = cbase + ADDR_BITS'(s);

      addr = p;
      newp = p;
      unique case (head_item.modifier)
         dag_pkg::MOD_PLAIN: newp = p;
         dag_pkg::MOD_POSTDEC, dag_pkg::MOD_POSTINC,
         dag_pkg::MOD_SUBAR0, dag_pkg::MOD_ADDAR0: newp = lin;
         dag_pkg::MOD_PREINC, dag_pkg::MOD_LKPRE: begin
            newp = lin;
            addr = lin;
         end
         dag_pkg::MOD_REVSUB: newp = rev(rev(p) - rev(ar0));
         dag_pkg::MOD_REVADD: newp = rev(rev(p) + rev(ar0));
         dag_pkg::MOD_CDEC, dag_pkg::MOD_CSUBAR0, dag_pkg::MOD_CINC,
         dag_pkg::MOD_CADDAR0: newp = use_circ ? circ : lin;
         dag_pkg::MOD_LKOFS: addr = lin;
         dag_pkg::MOD_LKCIRC: begin
            newp = use_circ ? circ : lin;
            addr = newp;
         end
         dag_pkg::MOD_LKABS: addr = ADDR_BITS'(head_item.data);
         default: newp = p;
      endcase

      rsp_in = '0;
      wr_en  = 1'b0;
      unique case (head_item.kind)
         dag_pkg::KIND_WRITE: begin
            wr_en                = 1'b1;
            newp                 = ADDR_BITS'(head_item.data);
            rsp_in.pointer_used  = head_item.ptr;
            rsp_in.pointer_after = 16'(newp);
         end
         dag_pkg::KIND_INDIRECT: begin
            wr_en                = 1'b1;
            rsp_in.address       = 16'(addr);
            rsp_in.pointer_used  = head_item.ptr;
            rsp_in.pointer_after = 16'(newp);
            rsp_in.two_word      = (head_item.modifier >= dag_pkg::MOD_LKOFS);
         end
         default: begin
            rsp_in.address = head_item.data;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < NUM_POINTERS; i++) begin
            ptr_ff[i] <= '0;
         end
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
         if (pop && wr_en) begin
            ptr_ff[idx] <= newp;
         end
      end
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: rtl/dsp_data_address_generator.sv
// Data-address generator top level: config registers, front, queue, back.
// Depends on dag_pkg, dag_front, dag_queue, dag_back and the defines header.
//
// Usage:
//  - req_*: one item per handshake, either a pointer load (mode 1) or an
//    operand byte to turn into a data address (mode 0).
//  - rsp_*: exactly one result item per request item, in order.
//  - csr_*: write-only registers, circular size (index 0) and the
//    compatibility pointer select (index 1); write only while idle.
// Timing:
//  - From acceptance to rsp_valid an item passes the front register, a
//    queue slot and the result register, in that order.
//  - Throughput is one item per cycle while rsp_ready stays high; the back
//    stage reads and updates the selected pointer in the same cycle, so
//    back-to-back items see each other's pointer updates.
//  - When rsp_ready is low, results hold; the two-entry queue and the front
//    register still take up to three more items before req_ready drops.
// Reset: pointer registers, circular size and compat mode clear to zero,
//   all pipeline valid flags clear.
`include "dsp_data_address_generator_defines.svh"
module dsp_data_address_generator #(
   parameter int ADDR_BITS    = 16,
   parameter int NUM_POINTERS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dag_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dag_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   logic [15:0]        circ_size_ff, circ_size_in;
   logic [15:0]        circ_mask_ff, circ_mask_in;
   logic               compat_ff, compat_in;
   dag_pkg::cfg_type   cfg;
   logic               q_push, q_full, q_pop, q_valid;
   dag_pkg::item_type  q_in_item, q_head;
   dag_pkg::qstat_type q_stat;

   // config writes; mask of the next power of two above the size is kept
   always_comb begin
      circ_size_in = circ_size_ff;
      compat_in    = compat_ff;
      if (csr_we) begin
         unique case (csr_index)
            dag_pkg::CSR_CIRC_SIZE: circ_size_in = csr_wdata;
            dag_pkg::CSR_COMPAT:    compat_in    = csr_wdata[0];
            default:                circ_size_in = circ_size_ff;
         endcase
      end
      for (int i = 0; i < 16; i++) begin
         circ_mask_in[i] = |(circ_size_in >> i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         circ_size_ff <= '0;
         circ_mask_ff <= '0;
         compat_ff    <= 1'b0;
      end else begin
         circ_size_ff <= circ_size_in;
         circ_mask_ff <= circ_mask_in;
         compat_ff    <= compat_in;
      end
   end

   assign cfg = '{circ_size: circ_size_ff, circ_mask: circ_mask_ff, compat: compat_ff};

   dag_front #(.ADDR_BITS(ADDR_BITS), .NUM_POINTERS(NUM_POINTERS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg         (cfg),
      .q_push      (q_push),
      .q_full      (q_full),
      .q_item      (q_in_item)
   );

   dag_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_in_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_head),
      .stat       (q_stat)
   );

   dag_back #(.ADDR_BITS(ADDR_BITS), .NUM_POINTERS(NUM_POINTERS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_valid),
      .head_item   (q_head),
      .pop         (q_pop),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // queue never overfills
   `DAG_ASSERT(a_q_bound, q_stat.count <= 2'(dag_pkg::QDEPTH))
   // a push is only issued with room left, even if a pop frees a slot
   `DAG_ASSERT(a_q_push_room, q_stat.push |-> (q_stat.count < 2'(dag_pkg::QDEPTH)))
   // every item taken by the back stage shows up as a result next cycle
   `DAG_ASSERT(a_pop_result, q_stat.pop |=> rsp_valid)

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the DSP data-address generator: random and directed items.
// Depends on dag_pkg and the dsp_data_address_generator RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   dag_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   dag_pkg::rsp_type rsp_payload;
   logic             csr_we = 1'b0;
   logic             csr_index = 1'b0;
   logic [15:0]      csr_wdata = '0;

   dsp_data_address_generator dut (.*);

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bench-side copy of the block state
   logic [15:0] ptr_regs [8];
   logic [15:0] buf_size;
   logic        compat_sel;

   dag_pkg::req_type pending_items [$];
   dag_pkg::rsp_type predicted_rsp [$];
   int      tx_idle = 0;   // percent of cycles the sender holds off
   int      rx_idle = 0;   // percent of cycles the receiver stalls
   int      errors = 0;
   bit      req_taken = 1'b0;

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [15:0] rev16(logic [15:0] v);
      logic [15:0] r;
      for (int i = 0; i < 16; i++) r[15 - i] = v[i];
      return r;
   endfunction

   // circular step: one wrap correction against buf_size, inside a 2^k window
   function automatic logic [15:0] circ_move(logic [15:0] p, int step);
      int n, t, sz, idx, s;
      sz = buf_size;
      if (sz == 0) return 16'(int'(p) + step);
      n = 1;
      t = sz;
      while (t != 0) begin
         n = n << 1;
         t = t >> 1;
      end
      idx = int'(p) & (n - 1);
      s = idx + step;
      if (s < 0) s += sz;
      else if (s >= sz) s -= sz;
      return 16'(int'(p) - idx + s);
   endfunction

   // predicts the result item of one accepted request and updates the pointers
   function automatic dag_pkg::rsp_type predict_address(dag_pkg::req_type r);
      dag_pkg::rsp_type o;
      logic [2:0] sel;
      logic [3:0] m;
      logic [15:0] p, ar0;
      o = '0;
      if (r.mode) begin
         ptr_regs[r.reg_index] = r.reg_value;
         o.pointer_used = r.reg_index;
         o.pointer_after = r.reg_value;
      end else if (!r.operand_byte[dag_pkg::OP_INDIRECT_BIT]) begin
         o.address = {9'b0, r.operand_byte[6:0]};
         if (r.base_select == dag_pkg::BASE_STACK) o.address += r.stack_pointer;
         else if (r.base_select == dag_pkg::BASE_PAGE) o.address += {r.data_page, 7'b0};
      end else begin
         m = r.operand_byte[6:3];
         sel = r.operand_byte[2:0];
         if (compat_sel && sel == 3'd0) sel = r.current_pointer;
         p = ptr_regs[sel];
         ar0 = ptr_regs[0];
         o.address = p;
         o.two_word = (m >= dag_pkg::MOD_LKOFS);
         case (m)
            dag_pkg::MOD_PLAIN:   ;
            dag_pkg::MOD_POSTDEC: p = p - 16'd1;
            dag_pkg::MOD_POSTINC: p = p + 16'd1;
            dag_pkg::MOD_PREINC: begin
               p = p + 16'd1;
               o.address = p;
            end
            dag_pkg::MOD_REVSUB:  p = rev16(rev16(p) - rev16(ar0));
            dag_pkg::MOD_SUBAR0:  p = p - ar0;
            dag_pkg::MOD_ADDAR0:  p = p + ar0;
            dag_pkg::MOD_REVADD:  p = rev16(rev16(p) + rev16(ar0));
            dag_pkg::MOD_CDEC:    p = circ_move(p, -1);
            dag_pkg::MOD_CSUBAR0: p = circ_move(p, -int'($signed(ar0)));
            dag_pkg::MOD_CINC:    p = circ_move(p, 1);
            dag_pkg::MOD_CADDAR0: p = circ_move(p, int'($signed(ar0)));
            dag_pkg::MOD_LKOFS:   o.address = p + r.long_offset;
            dag_pkg::MOD_LKPRE: begin
               p = p + r.long_offset;
               o.address = p;
            end
            dag_pkg::MOD_LKCIRC: begin
               p = circ_move(p, int'($signed(r.long_offset)));
               o.address = p;
            end
            default:     o.address = r.long_offset;
         endcase
         ptr_regs[sel] = p;
         o.pointer_used = sel;
         o.pointer_after = p;
      end
      return o;
   endfunction

   // driver: new items at the falling edge, valid held until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle) begin
            req_payload <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= rx_idle);
   end

   // monitor: mirrors csr writes, checks results, predicts on acceptance
   always @(posedge clock) begin
      dag_pkg::rsp_type want;
      req_taken = req_valid && req_ready && !reset;
      if (reset) begin
         for (int i = 0; i < 8; i++) ptr_regs[i] = '0;
         buf_size = '0;
         compat_sel = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               dag_pkg::CSR_CIRC_SIZE: buf_size = csr_wdata;
               dag_pkg::CSR_COMPAT:    compat_sel = csr_wdata[0];
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               report_mismatch("unexpected item", rsp_payload.address, 16'h0);
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_payload.address !== want.address)
                  report_mismatch("address", rsp_payload.address, want.address);
               if (rsp_payload.pointer_used !== want.pointer_used)
                  report_mismatch("pointer_used", 16'(rsp_payload.pointer_used),
                                  16'(want.pointer_used));
               if (rsp_payload.pointer_after !== want.pointer_after)
                  report_mismatch("pointer_after", rsp_payload.pointer_after,
                                  want.pointer_after);
               if (rsp_payload.two_word !== want.two_word)
                  report_mismatch("two_word", 16'(rsp_payload.two_word),
                                  16'(want.two_word));
            end
         end
         if (req_taken) predicted_rsp.push_back(predict_address(req_payload));
      end
   end

   function automatic dag_pkg::req_type rand_item();
      dag_pkg::req_type r;
      r = dag_pkg::req_type'(($bits(dag_pkg::req_type))'({$urandom, $urandom, $urandom}));
      r.base_select = 2'($urandom_range(3));
      // mostly indirect operands, some loads, some direct
      case ($urandom_range(9))
         0, 1: begin
            r.mode = 1'b1;
            // small values keep AR0 steps and pointers near the buffers
            if ($urandom_range(1)) r.reg_value = 16'($urandom_range(40));
         end
         2:       r.mode = 1'b0;
         default: begin
            r.mode = 1'b0;
            r.operand_byte[7] = 1'b1;
         end
      endcase
      if ($urandom_range(1)) r.long_offset = 16'($signed(8'($urandom)));
      return r;
   endfunction

   task automatic add_item(logic mode, logic [7:0] opb, logic [2:0] idx, logic [15:0] val);
      dag_pkg::req_type r;
      r = rand_item();
      r.mode = mode;
      r.operand_byte = opb;
      r.reg_index = idx;
      r.reg_value = val;
      pending_items.push_back(r);
   endtask

   // wait until every queued item is sent and every result has come back
   task automatic drain();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || predicted_rsp.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [15:0] sizes [8] = '{16'd0, 16'd1, 16'hffff, 16'h8000, 16'd8, 16'd0, 16'd16, 16'd5};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: loads, every modifier, every direct base
      write_csr(dag_pkg::CSR_CIRC_SIZE, 16'd0);
      write_csr(dag_pkg::CSR_COMPAT, 16'd0);
      add_item(1'b1, 8'h00, 3'd0, 16'd1);
      add_item(1'b1, 8'h00, 3'd1, 16'hfff0);
      add_item(1'b1, 8'h00, 3'd7, 16'hffff);
      for (int m = 0; m < 16; m++) add_item(1'b0, {1'b1, 4'(m), 3'd1}, 3'd0, 16'd0);
      for (int b = 0; b < 4; b++) begin
         dag_pkg::req_type r;
         r = rand_item();
         r.mode = 1'b0;
         r.operand_byte = 8'h7f;
         r.base_select = 2'(b);
         r.data_page = 9'h1ff;
         r.stack_pointer = 16'hffff;
         pending_items.push_back(r);
      end
      add_item(1'b0, 8'hff, 3'd0, 16'd0);
      drain();

      // random phases: new buffer size and compat select between them
      for (int k = 0; k < 8; k++) begin
         write_csr(dag_pkg::CSR_CIRC_SIZE, (k == 7) ? 16'($urandom_range(2, 64)) : sizes[k]);
         write_csr(dag_pkg::CSR_COMPAT, 16'(k % 2));
         tx_idle = (k < 3) ? 16 : (k < 6) ? 51 : 0;
         rx_idle = (k < 3) ? 51 : (k < 6) ? 16 : 0;
         for (int i = 0; i < 190; i++) pending_items.push_back(rand_item());
         drain();
      end

      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
